// ===== src/ple_pkg.sv =====
// shared types and codes for the positional list engine
package ple_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed port widths
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // index width for the cell row, wide enough to hold the largest capacity
    localparam int IDX_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_ALL  = 3'd6;
    localparam logic [OP_W-1:0] OP_COUNT     = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // what the cell row does in one cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_cmd_t;

    // broadcast control for every cell
    typedef struct packed {
        cell_cmd_t        cmd;
        logic [IDX_W-1:0] idx;
    } cell_ctrl_t;

endpackage

// ===== src/ple_cell.sv =====
// one storage cell of the list row, fed by its two neighbors
module ple_cell
    import ple_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] new_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] head_data,
    output logic [DATA_WIDTH-1:0] data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // pick the next entry for this place
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.cmd)
            CELL_INSERT:
            begin
                if (MY_IDX == ctrl.idx)
                begin
                    data_next = new_data;
                end
                else if (MY_IDX > ctrl.idx)
                begin
                    data_next = left_data;
                end
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= ctrl.idx)
                begin
                    data_next = right_data;
                end
            end
            CELL_ROTATE:
            begin
                // idx marks the last occupied place, which takes the head
                if (MY_IDX < ctrl.idx)
                begin
                    data_next = right_data;
                end
                else if (MY_IDX == ctrl.idx)
                begin
                    data_next = head_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== src/positional_list_engine.sv =====
// top level of the positional list engine: control, status and the cell row
//
// An ordered list of up to CAPACITY signed entries lives in a row of cells.
// Insert and delete shift every entry behind the position by one place in the
// same cycle, and each insert, delete or count request gives one result word.
// A read-all request on a non-empty list is accepted and then streams one word
// per entry, front first, by rotating the occupied cells one place per beat;
// the list is back in order after the last beat. A new request is taken once
// the previous one has handed all of its words to the output register and that
// register is free.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       operation,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [POS_W-1:0]      position,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic signed [VALUE_W-1:0] element,
    output logic                  element_valid,
    output logic [COUNT_W-1:0]    entry_count,
    output logic                  last_of_run
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_STREAM = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              out_valid_reg, out_valid_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  element_reg, element_next;
    logic                elem_valid_reg, elem_valid_next;
    logic [COUNT_W-1:0]  entry_count_reg, entry_count_next;
    logic                last_reg, last_next;

    logic                  in_fire;
    logic                  out_free;
    logic [IDX_W-1:0]      cnt_idx;
    logic [IDX_W-1:0]      pos_idx;
    logic                  is_full;
    logic                  is_empty;
    logic [STATUS_W-1:0]   op_status;
    logic                  do_insert;
    logic                  do_delete;
    logic                  do_stream;
    logic [IDX_W-1:0]      op_idx;
    cell_ctrl_t            cell_ctrl;
    logic [DATA_WIDTH-1:0] store_data;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [VALUE_W-1:0]    head_elem;

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;

    // value as stored in a cell, and the head cell as a result element
    generate
        if (DATA_WIDTH <= VALUE_W)
        begin : g_narrow
            assign store_data = value[DATA_WIDTH-1:0];
            assign head_elem  = VALUE_W'($signed(cell_data[0]));
        end
        else
        begin : g_wide
            assign store_data = {{(DATA_WIDTH-VALUE_W){value[VALUE_W-1]}}, value};
            assign head_elem  = cell_data[0][VALUE_W-1:0];
        end
    endgenerate

    // request decode
    assign cnt_idx  = IDX_W'(count_reg);
    assign pos_idx  = IDX_W'(position);
    assign is_full  = (cnt_idx == CAP_IDX);
    assign is_empty = (cnt_idx == '0);

    always_comb
    begin
        op_status = ST_OK;
        do_insert = 1'b0;
        do_delete = 1'b0;
        do_stream = 1'b0;
        op_idx    = '0;
        case (operation)
            OP_INS_FRONT:
            begin
                if (is_full)
                begin
                    op_status = ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                end
            end
            OP_INS_BACK:
            begin
                op_idx = cnt_idx;
                if (is_full)
                begin
                    op_status = ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                end
            end
            OP_INS_AT:
            begin
                op_idx = pos_idx - IDX_W'(1);
                if (is_full)
                begin
                    op_status = ST_FULL;
                end
                else if (pos_idx == '0 || pos_idx > cnt_idx + IDX_W'(1))
                begin
                    op_status = ST_BADPOS;
                end
                else
                begin
                    do_insert = 1'b1;
                end
            end
            OP_DEL_FRONT:
            begin
                if (is_empty)
                begin
                    op_status = ST_EMPTY;
                end
                else
                begin
                    do_delete = 1'b1;
                end
            end
            OP_DEL_BACK:
            begin
                op_idx = cnt_idx - IDX_W'(1);
                if (is_empty)
                begin
                    op_status = ST_EMPTY;
                end
                else
                begin
                    do_delete = 1'b1;
                end
            end
            OP_DEL_AT:
            begin
                op_idx = pos_idx - IDX_W'(1);
                if (is_empty)
                begin
                    op_status = ST_EMPTY;
                end
                else if (pos_idx == '0 || pos_idx > cnt_idx)
                begin
                    op_status = ST_BADPOS;
                end
                else
                begin
                    do_delete = 1'b1;
                end
            end
            OP_READ_ALL:
            begin
                if (is_empty)
                begin
                    op_status = ST_EMPTY;
                end
                else
                begin
                    do_stream = 1'b1;
                end
            end
            OP_COUNT:
            begin
                op_status = ST_OK;
            end
            default:
            begin
                op_status = ST_OK;
            end
        endcase
    end

    // control and result sequencing
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        element_next     = element_reg;
        elem_valid_next  = elem_valid_reg;
        entry_count_next = entry_count_reg;
        last_next        = last_reg;
        cell_ctrl.cmd    = CELL_HOLD;
        cell_ctrl.idx    = op_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (do_stream)
                    begin
                        remain_next = count_reg;
                        state_next  = S_STREAM;
                    end
                    else
                    begin
                        if (do_insert)
                        begin
                            count_next    = count_reg + CNT_W'(1);
                            cell_ctrl.cmd = CELL_INSERT;
                        end
                        else if (do_delete)
                        begin
                            count_next    = count_reg - CNT_W'(1);
                            cell_ctrl.cmd = CELL_DELETE;
                        end
                        out_valid_next   = 1'b1;
                        status_next      = op_status;
                        element_next     = '0;
                        elem_valid_next  = 1'b0;
                        entry_count_next = COUNT_W'(count_next);
                        last_next        = 1'b1;
                    end
                end
            end
            S_STREAM:
            begin
                // one entry per beat from the head, then rotate
                if (out_free)
                begin
                    cell_ctrl.cmd    = CELL_ROTATE;
                    cell_ctrl.idx    = cnt_idx - IDX_W'(1);
                    out_valid_next   = 1'b1;
                    status_next      = ST_OK;
                    element_next     = head_elem;
                    elem_valid_next  = 1'b1;
                    entry_count_next = COUNT_W'(count_reg);
                    last_next        = (remain_reg == CNT_W'(1));
                    remain_next      = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output word registers
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        element_reg     <= element_next;
        elem_valid_reg  <= elem_valid_next;
        entry_count_reg <= entry_count_next;
        last_reg        <= last_next;
    end

    // row of cells
    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;

            if (i == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_inner_l
                assign left_d = cell_data[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_inner_r
                assign right_d = cell_data[i+1];
            end

            ple_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (i)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .new_data   (store_data),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (cell_data[0]),
                .data       (cell_data[i])
            );
        end
    endgenerate

    // outputs
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign element       = element_reg;
    assign element_valid = elem_valid_reg;
    assign entry_count   = entry_count_reg;
    assign last_of_run   = last_reg;

endmodule
